### hdl/ps2_mouse_packet_decoder_defines.svh
// Assertion macros shared by the mouse packet decoder modules.
`ifndef PS2_MOUSE_PACKET_DECODER_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PS2MD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PS2MD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ps2md_pkg.sv
// Shared types and codes for the mouse packet decoder.
package ps2md_pkg;

	// Byte position within a three-byte packet
	localparam logic [1:0] POS_STATUS = 2'd0;
	localparam logic [1:0] POS_X      = 2'd1;
	localparam logic [1:0] POS_Y      = 2'd2;

	// Button event codes
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	// Status byte bit positions
	localparam int unsigned ST_X_SIGN = 4;
	localparam int unsigned ST_Y_SIGN = 5;
	localparam int unsigned ST_X_OVF  = 6;
	localparam int unsigned ST_Y_OVF  = 7;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned MOVEX_W = 9;
	localparam int unsigned MOVEY_W = 10;
	localparam int unsigned EVENT_W = 2;
	localparam int unsigned NUM_BTN = 3;
	localparam int unsigned OUT_W   = 32;

	// One complete, non-overflowed packet handed to the decode stage
	typedef struct packed {
		logic [NUM_BTN-1:0] buttons;  // left, right, middle from bit 0
		logic               x_sign;
		logic               y_sign;
		logic [BYTE_W-1:0]  x_delta;
		logic [BYTE_W-1:0]  y_delta;
	} pkt_t;

endpackage

### hdl/ps2md_assembler.sv
// Byte position counter and packet assembly register.
module ps2md_assembler
	import ps2md_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              pkt_valid,
	output pkt_t              pkt,
	input  logic              pkt_ready
);

	`include "ps2_mouse_packet_decoder_defines.svh"

	logic [1:0]        pos_q;
	logic [BYTE_W-1:0] status_q;
	logic [BYTE_W-1:0] x_delta_q;
	logic              pkt_valid_s1;
	pkt_t              pkt_s1;
	logic              accept;
	logic              overflow;

	// Take a beat when the packet register is free or being drained
	assign in_ready  = !pkt_valid_s1 || pkt_ready;
	assign accept    = in_valid && in_ready;
	assign overflow  = status_q[ST_X_OVF] || status_q[ST_Y_OVF];
	assign pkt_valid = pkt_valid_s1;
	assign pkt       = pkt_s1;

	// Advance the position counter and collect packet bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_STATUS;
			status_q     <= '0;
			x_delta_q    <= '0;
			pkt_valid_s1 <= 1'b0;
		end else begin
			// raise on a complete packet with both overflow bits clear, else drop once taken
			if (accept && pos_q == POS_Y && !overflow) begin
				pkt_valid_s1 <= 1'b1;
			end else if (pkt_ready) begin
				pkt_valid_s1 <= 1'b0;
			end
			if (accept) begin
				unique case (pos_q)
					POS_X: begin
						x_delta_q <= in_byte;
						pos_q     <= POS_Y;
					end
					POS_Y: begin
						pos_q <= POS_STATUS;
					end
					default: begin
						status_q <= in_byte;
						pos_q    <= POS_X;
					end
				endcase
			end
		end
	end

	// Load the packet payload on the third byte
	always_ff @(posedge clk) begin
		if (accept && pos_q == POS_Y) begin
			pkt_s1.buttons <= status_q[NUM_BTN-1:0];
			pkt_s1.x_sign  <= status_q[ST_X_SIGN];
			pkt_s1.y_sign  <= status_q[ST_Y_SIGN];
			pkt_s1.x_delta <= x_delta_q;
			pkt_s1.y_delta <= in_byte;
		end
	end

	`PS2MD_ASSERT_NEXT(a_wrap_after_y, accept && pos_q == POS_Y, pos_q == POS_STATUS,
		"position counter did not wrap after third byte")
	`PS2MD_ASSERT_IMP(a_pkt_from_y, $rose(pkt_valid_s1), $past(pos_q) == POS_Y,
		"packet raised without a third byte")
	`PS2MD_ASSERT_NEXT(a_pkt_hold, pkt_valid_s1 && !pkt_ready, pkt_valid_s1 && $stable(pkt_s1),
		"stalled packet lost or changed")

endmodule

### hdl/ps2md_decoder.sv
// Motion extension, button event detection and result register.
module ps2md_decoder
	import ps2md_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pkt_valid,
	input  pkt_t               pkt,
	output logic               pkt_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [MOVEX_W-1:0] move_x,
	output logic [MOVEY_W-1:0] move_y,
	output logic [EVENT_W-1:0] left_event,
	output logic [EVENT_W-1:0] right_event,
	output logic [EVENT_W-1:0] middle_event
);

	`include "ps2_mouse_packet_decoder_defines.svh"

	logic [NUM_BTN-1:0] held_q;
	logic               out_valid_q;
	logic [MOVEX_W-1:0] move_x_q;
	logic [MOVEY_W-1:0] move_y_q;
	logic [EVENT_W-1:0] left_q;
	logic [EVENT_W-1:0] right_q;
	logic [EVENT_W-1:0] middle_q;
	logic               take;
	logic [MOVEY_W-1:0] y_ext;

	// Compare one stored button state with the new one
	function automatic logic [EVENT_W-1:0] btn_event(input logic held, input logic now);
		logic [EVENT_W-1:0] ev;
		ev = EV_NONE;
		if (held && !now) begin
			ev = EV_RELEASE;
		end else if (!held && now) begin
			ev = EV_PRESS;
		end
		return ev;
	endfunction

	assign pkt_ready = !out_valid_q || out_ready;
	assign take      = pkt_valid && pkt_ready;
	assign y_ext     = {pkt.y_sign, pkt.y_sign, pkt.y_delta};

	// Hold result valid until taken; track button states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			held_q      <= pkt.buttons;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			move_x_q <= {pkt.x_sign, pkt.x_delta};
			move_y_q <= MOVEY_W'(~y_ext + 1'b1);
			left_q   <= btn_event(held_q[0], pkt.buttons[0]);
			right_q  <= btn_event(held_q[1], pkt.buttons[1]);
			middle_q <= btn_event(held_q[2], pkt.buttons[2]);
		end
	end

	assign out_valid    = out_valid_q;
	assign move_x       = move_x_q;
	assign move_y       = move_y_q;
	assign left_event   = left_q;
	assign right_event  = right_q;
	assign middle_event = middle_q;

	`PS2MD_ASSERT_IMP(a_left_press, out_valid_q && left_q == EV_PRESS, held_q[0],
		"left press shown but button not held")
	`PS2MD_ASSERT_IMP(a_left_release, out_valid_q && left_q == EV_RELEASE, !held_q[0],
		"left release shown but button still held")
	`PS2MD_ASSERT_NEXT(a_held_update, take, held_q == $past(pkt.buttons),
		"button states not updated from packet")
	`PS2MD_ASSERT_NEXT(a_drain, out_valid_q && out_ready && !take, !out_valid_q,
		"result repeated after being taken")

endmodule

### hdl/ps2_mouse_packet_decoder.sv
// Top level of the mouse three-byte packet decoder.
//
// Usage:
//   Slave side (s_axis_*) takes one received mouse byte per beat. Bytes are
//   grouped into packets of three: status, X delta, Y delta. The master side
//   (m_axis_*) gives one beat per complete packet whose overflow bits are
//   both clear; an overflowed packet is dropped and gives no beat.
//   The result reaches m_axis_tvalid after the edge that takes the third
//   byte, through the packet register, then the result register.
//   Throughput: one byte per cycle unless stalled; a result every third byte
//   at best. The two-stage register path sets the rate, with no iteration.
//   Stall: when the receiver holds m_axis_tready low the result stays put;
//   the packet register still takes bytes until a second packet is waiting,
//   after which s_axis_tready falls until the result is drained.
//   Reset: arst_n low clears the byte position, the stored status and X
//   bytes and the button states (all released), and empties both registers.
//   Button events are 0 none, 1 pressed, 2 released, per button.
module ps2_mouse_packet_decoder
	import ps2md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [8:0] move_x, [18:9] move_y,
	                                    // [20:19] left_event, [22:21] right_event,
	                                    // [24:23] middle_event, [31:25] zero
);

	logic               pkt_valid;
	logic               pkt_ready;
	pkt_t               pkt;
	logic [MOVEX_W-1:0] move_x;
	logic [MOVEY_W-1:0] move_y;
	logic [EVENT_W-1:0] left_event;
	logic [EVENT_W-1:0] right_event;
	logic [EVENT_W-1:0] middle_event;

	// Assemble bytes into packets
	ps2md_assembler u_assembler (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.pkt_valid (pkt_valid),
		.pkt       (pkt),
		.pkt_ready (pkt_ready)
	);

	// Decode packets into results
	ps2md_decoder u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.pkt_valid    (pkt_valid),
		.pkt          (pkt),
		.pkt_ready    (pkt_ready),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.move_x       (move_x),
		.move_y       (move_y),
		.left_event   (left_event),
		.right_event  (right_event),
		.middle_event (middle_event)
	);

	// Pack the result beat, padded with zeros
	assign m_axis_tdata = {7'd0, middle_event, right_event, left_event, move_y, move_x};

endmodule

### tb/ps2_mouse_packet_decoder_tb.sv
// Self-checking testbench for the mouse packet decoder: directed byte table, then random packets.
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_tb;
	import ps2md_pkg::*;

	localparam int unsigned RANDOM_BYTES = 1300;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned IDLE_PCT     = 17;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [MOVEX_W-1:0] move_x;
		logic [MOVEY_W-1:0] move_y;
		logic [EVENT_W-1:0] left_ev;
		logic [EVENT_W-1:0] right_ev;
		logic [EVENT_W-1:0] middle_ev;
	} mouse_result_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		bit                typed;
		mouse_result_t     res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	// Predictor state
	logic [1:0]         pkt_pos;
	logic [BYTE_W-1:0]  pkt_status;
	logic [BYTE_W-1:0]  pkt_x;
	logic [NUM_BTN-1:0] btn_held;

	mouse_result_t pending_moves[$];
	int unsigned   error_count;
	int unsigned   cycle_count;
	bit            quiet;

	// Directed bytes, three per packet; typed rows carry the result of their packet
	stim_row_t directed_rows [24] = '{
		// all zero packet
		'{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{9'h000, 10'h000, EV_NONE, EV_NONE, EV_NONE}},
		// all buttons pressed, largest positive deltas
		'{8'h07, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b1, '{9'h0FF, 10'h301, EV_PRESS, EV_PRESS, EV_PRESS}},
		// both signs and the constant bit set, zero deltas, all released
		'{8'h38, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{9'h100, 10'h100, EV_RELEASE, EV_RELEASE, EV_RELEASE}},
		// both overflow bits: dropped, buttons untouched
		'{8'hC7, 1'b0, '0}, '{8'h12, 1'b0, '0}, '{8'h34, 1'b0, '0},
		// X overflow only
		'{8'h45, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},
		// Y overflow only
		'{8'h86, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h80, 1'b0, '0},
		// left press with negative deltas
		'{8'h31, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h01, 1'b0, '0},
		// right press, left release
		'{8'h0A, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'h80, 1'b0, '0}
	};

	ps2_mouse_packet_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Advance the packet position on one accepted byte; return 1 when a result is due
	function automatic bit decode_mouse_byte(input logic [BYTE_W-1:0] b,
			output mouse_result_t r);
		logic [MOVEY_W-1:0] y_ext;
		r = '0;
		if (pkt_pos == POS_X) begin
			pkt_x   = b;
			pkt_pos = POS_Y;
			return 1'b0;
		end
		if (pkt_pos != POS_Y) begin
			pkt_status = b;
			pkt_pos    = POS_X;
			return 1'b0;
		end
		pkt_pos = POS_STATUS;
		if (pkt_status[ST_X_OVF] || pkt_status[ST_Y_OVF])
			return 1'b0;
		r.move_x = {pkt_status[ST_X_SIGN], pkt_x};
		y_ext    = {{2{pkt_status[ST_Y_SIGN]}}, b};
		r.move_y = -y_ext;
		for (int i = 0; i < NUM_BTN; i++) begin
			logic [EVENT_W-1:0] ev;
			ev = EV_NONE;
			if (btn_held[i] && !pkt_status[i]) begin
				ev = EV_RELEASE;
				btn_held[i] = 1'b0;
			end else if (!btn_held[i] && pkt_status[i]) begin
				ev = EV_PRESS;
				btn_held[i] = 1'b1;
			end
			case (i)
				0: r.left_ev = ev;
				1: r.right_ev = ev;
				default: r.middle_ev = ev;
			endcase
		end
		return 1'b1;
	endfunction

	// Offer one byte, hold it until taken, then queue what it should produce
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
			input mouse_result_t typed_res);
		mouse_result_t r;
		bit            due;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		due = decode_mouse_byte(b, r);
		if (typed)
			pending_moves.push_back(typed_res);
		else if (due)
			pending_moves.push_back(r);
	endtask

	// Drop the sender and wait until every expected beat is out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_moves.size() != 0);
	endtask

	function automatic logic [BYTE_W-1:0] pick_delta();
		logic [BYTE_W-1:0] corners [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
		if ($urandom_range(99) < 10)
			return corners[$urandom_range(4)];
		return BYTE_W'($urandom);
	endfunction

	// Receiver: stall at random except in the quiet stretch
	always @(posedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// Check every result beat against the oldest expectation
	always @(posedge clk) begin
		mouse_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_moves.size() == 0) begin
				$error("unexpected result beat, tdata=%h", m_axis_tdata);
				error_count++;
			end else begin
				want = pending_moves.pop_front();
				if (m_axis_tdata[8:0] !== want.move_x) begin
					$error("move_x: expected %h, got %h", want.move_x, m_axis_tdata[8:0]);
					error_count++;
				end
				if (m_axis_tdata[18:9] !== want.move_y) begin
					$error("move_y: expected %h, got %h", want.move_y, m_axis_tdata[18:9]);
					error_count++;
				end
				if (m_axis_tdata[20:19] !== want.left_ev) begin
					$error("left_event: expected %0d, got %0d", want.left_ev,
						m_axis_tdata[20:19]);
					error_count++;
				end
				if (m_axis_tdata[22:21] !== want.right_ev) begin
					$error("right_event: expected %0d, got %0d", want.right_ev,
						m_axis_tdata[22:21]);
					error_count++;
				end
				if (m_axis_tdata[24:23] !== want.middle_ev) begin
					$error("middle_event: expected %0d, got %0d", want.middle_ev,
						m_axis_tdata[24:23]);
					error_count++;
				end
				if (m_axis_tdata[31:25] !== 7'd0) begin
					$error("pad: expected 0, got %h", m_axis_tdata[31:25]);
					error_count++;
				end
			end
		end
	end

	// Hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ps2_mouse_packet_decoder_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned       sent;
		logic [BYTE_W-1:0] status;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		pkt_pos       = POS_STATUS;
		pkt_status    = '0;
		pkt_x         = '0;
		btn_held      = '0;
		error_count   = 0;
		cycle_count   = 0;
		quiet         = 1'b0;
		sent          = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].res);

		// Random packets; a few are overflowed and dropped
		while (sent < RANDOM_BYTES) begin
			quiet = (sent >= 400 && sent < 600);
			if (sent >= 800 && sent < 803)
				wait_drained();
			status = BYTE_W'($urandom);
			if ($urandom_range(99) >= 12)
				status[ST_Y_OVF:ST_X_OVF] = 2'b00;
			else if (status[ST_Y_OVF:ST_X_OVF] == 2'b00)
				status[ST_Y_OVF:ST_X_OVF] = 2'($urandom_range(3, 1));
			send_byte(status, 1'b0, '0);
			send_byte(pick_delta(), 1'b0, '0);
			send_byte(pick_delta(), 1'b0, '0);
			sent += 3;
		end
		quiet = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ps2_mouse_packet_decoder_tb: PASS");
		else
			$display("ps2_mouse_packet_decoder_tb: FAIL");
		$finish;
	end

endmodule
